FILE: hdl/lsu_pkg.sv
// shared types, codes and helper functions of the load/store unit
package lsu_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW = $clog2(REG_COUNT);

    localparam logic [1:0] OP_INSTR = 2'd0;
    localparam logic [1:0] OP_RDATA = 2'd1;
    localparam logic [1:0] OP_SETREG = 2'd2;

    localparam logic [3:0] K_LBZ = 4'd0;
    localparam logic [3:0] K_LHA = 4'd1;
    localparam logic [3:0] K_LHZ = 4'd2;
    localparam logic [3:0] K_LWZ = 4'd3;
    localparam logic [3:0] K_STB = 4'd4;
    localparam logic [3:0] K_STH = 4'd5;
    localparam logic [3:0] K_STW = 4'd6;
    localparam logic [3:0] K_LHBRX = 4'd7;
    localparam logic [3:0] K_LWBRX = 4'd8;
    localparam logic [3:0] K_STHBRX = 4'd9;
    localparam logic [3:0] K_STWBRX = 4'd10;
    localparam logic [3:0] K_LMW = 4'd11;
    localparam logic [3:0] K_STMW = 4'd12;
    localparam logic [3:0] K_LWARX = 4'd13;
    localparam logic [3:0] K_STWCX = 4'd14;
    localparam logic [3:0] K_NONE = 4'd15;

    localparam logic [1:0] MEM_NONE = 2'd0;
    localparam logic [1:0] MEM_READ = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [1:0] SIZE_B = 2'd0;
    localparam logic [1:0] SIZE_H = 2'd1;
    localparam logic [1:0] SIZE_W = 2'd2;

    localparam logic [31:0] NO_RESERVATION = 32'hFFFF_FFFF;
    localparam logic [3:0] CR0_EQ = 4'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] kind;
        logic upd;
        logic idx;
        logic [1:0] size;
        logic [4:0] t;
        logic [4:0] a;
        logic [4:0] b;
        logic [15:0] disp;
        logic [31:0] data;
        logic so;
    } item_t;

    typedef struct packed {
        logic [1:0] mem_op;
        logic [31:0] mem_address;
        logic [1:0] mem_size;
        logic [31:0] mem_write_data;
        logic reg_write_valid;
        logic [4:0] reg_index;
        logic [31:0] reg_value;
        logic cr0_valid;
        logic [3:0] cr0_bits;
        logic last;
    } result_t;

    function automatic logic [31:0] swap16(input logic [31:0] v);
        swap16 = {16'd0, v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

FILE: hdl/lsu_ram.sv
// generic single-write, single-read RAM with registered read data
module lsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/lsu_front.sv
// request decode and two-entry queue toward the execution side
module lsu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output lsu_pkg::item_t       q_item
);

    lsu_pkg::item_t dec;
    lsu_pkg::item_t buf_reg [2];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    always_comb
    begin
        dec.op = s_tuser;
        dec.kind = s_tdata[3:0];
        dec.upd = s_tdata[4];
        dec.idx = s_tdata[5];
        dec.t = s_tdata[10:6];
        dec.a = s_tdata[15:11];
        dec.b = s_tdata[20:16];
        dec.disp = s_tdata[36:21];
        dec.data = s_tdata[68:37];
        dec.so = s_tdata[69];
        // normalized addressing form per access kind
        if (dec.kind >= lsu_pkg::K_LHBRX)
        begin
            dec.upd = 1'b0;
            dec.idx = !(dec.kind == lsu_pkg::K_LMW || dec.kind == lsu_pkg::K_STMW);
        end
        unique case (dec.kind)
            lsu_pkg::K_LBZ, lsu_pkg::K_STB: dec.size = lsu_pkg::SIZE_B;
            lsu_pkg::K_LHA, lsu_pkg::K_LHZ, lsu_pkg::K_STH, lsu_pkg::K_LHBRX,
            lsu_pkg::K_STHBRX: dec.size = lsu_pkg::SIZE_H;
            default: dec.size = lsu_pkg::SIZE_W;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = buf_reg[rp_reg];
    assign push = s_tvalid && s_tready;
    assign pop = q_valid && q_ready;

    always_comb
    begin
        wp_next = push ? !wp_reg : wp_reg;
        rp_next = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hdl/lsu_back.sv
// execution side: register file, address generation, sequencing and result register
module lsu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  lsu_pkg::item_t       q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsu_pkg::result_t     out_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_RA, S_RB, S_RT, S_EA, S_EXEC, S_MRD, S_MOUT
    } state_t;

    state_t state_reg, state_next;
    lsu_pkg::item_t it_reg, it_next;
    logic [31:0] ra_reg, ra_next, rb_reg, rb_next, rt_reg, rt_next, ea_reg, ea_next;
    logic [4:0] cur_reg, cur_next;
    logic [31:0] maddr_reg, maddr_next;
    logic [lsu_pkg::REG_COUNT-1:0] vbits_reg, vbits_next;
    logic rvalid_reg;
    logic [3:0] pkind_reg, pkind_next;
    logic [4:0] pdest_reg, pdest_next;
    logic [5:0] pcnt_reg, pcnt_next;
    logic res_held_reg, res_held_next;
    logic [31:0] res_addr_reg, res_addr_next;
    logic ov_reg, ov_next;
    lsu_pkg::result_t out_reg, out_next;

    logic we;
    logic [lsu_pkg::REG_AW-1:0] waddr, raddr;
    logic [31:0] wdata, ram_rdata, rdata_eff, base, v;
    logic out_free, ok;

    lsu_ram #(.WIDTH(32), .DEPTH(lsu_pkg::REG_COUNT)) u_gpr (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(ram_rdata)
    );

    assign rdata_eff = rvalid_reg ? ram_rdata : 32'd0;
    assign out_valid = ov_reg;
    assign out_res = out_reg;

    always_comb
    begin
        state_next = state_reg;
        it_next = it_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        rt_next = rt_reg;
        ea_next = ea_reg;
        cur_next = cur_reg;
        maddr_next = maddr_reg;
        vbits_next = vbits_reg;
        pkind_next = pkind_reg;
        pdest_next = pdest_reg;
        pcnt_next = pcnt_reg;
        res_held_next = res_held_reg;
        res_addr_next = res_addr_reg;
        out_next = out_reg;
        out_free = !ov_reg || out_ready;
        ov_next = ov_reg && !out_ready;
        q_ready = 1'b0;
        we = 1'b0;
        waddr = it_reg.a;
        wdata = ea_reg;
        raddr = it_reg.a;
        ok = res_held_reg && (ea_reg == res_addr_reg);
        base = it_reg.idx ? rb_reg : {{16{it_reg.disp[15]}}, it_reg.disp};
        unique case (pkind_reg)
            lsu_pkg::K_LBZ: v = {24'd0, it_reg.data[7:0]};
            lsu_pkg::K_LHA: v = {{16{it_reg.data[15]}}, it_reg.data[15:0]};
            lsu_pkg::K_LHZ: v = {16'd0, it_reg.data[15:0]};
            lsu_pkg::K_LHBRX: v = lsu_pkg::swap16(it_reg.data);
            lsu_pkg::K_LWBRX: v = lsu_pkg::swap32(it_reg.data);
            default: v = it_reg.data;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready = 1'b1;
                    it_next = q_item;
                    unique case (q_item.op)
                        lsu_pkg::OP_INSTR:
                        begin
                            pcnt_next = 6'd0;
                            if (q_item.kind != lsu_pkg::K_NONE)
                            begin
                                state_next = S_RA;
                            end
                        end
                        lsu_pkg::OP_RDATA:
                        begin
                            if (pcnt_reg != 6'd0)
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        lsu_pkg::OP_SETREG: state_next = S_EXEC;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RA:
            begin
                raddr = it_reg.a;
                state_next = S_RB;
            end
            S_RB:
            begin
                raddr = it_reg.b;
                ra_next = rdata_eff;
                state_next = S_RT;
            end
            S_RT:
            begin
                raddr = it_reg.t;
                rb_next = rdata_eff;
                state_next = S_EA;
            end
            S_EA:
            begin
                rt_next = rdata_eff;
                ea_next = (it_reg.upd || it_reg.a != 5'd0) ? base + ra_reg : base;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_next = '0;
                    out_next.last = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                    unique case (it_reg.op)
                        lsu_pkg::OP_RDATA:
                        begin
                            we = 1'b1;
                            waddr = pdest_reg;
                            wdata = v;
                            out_next.reg_write_valid = 1'b1;
                            out_next.reg_index = pdest_reg;
                            out_next.reg_value = v;
                            pdest_next = pdest_reg + 5'd1;
                            pcnt_next = pcnt_reg - 6'd1;
                        end
                        lsu_pkg::OP_SETREG:
                        begin
                            we = 1'b1;
                            waddr = it_reg.t;
                            wdata = it_reg.data;
                            out_next.reg_write_valid = 1'b1;
                            out_next.reg_index = it_reg.t;
                            out_next.reg_value = it_reg.data;
                        end
                        default:
                        begin
                            unique case (it_reg.kind)
                                lsu_pkg::K_LMW, lsu_pkg::K_STMW:
                                begin
                                    ov_next = ov_reg && !out_ready;
                                    cur_next = it_reg.t;
                                    maddr_next = ea_reg;
                                    state_next = S_MRD;
                                    if (it_reg.kind == lsu_pkg::K_LMW)
                                    begin
                                        pkind_next = it_reg.kind;
                                        pdest_next = it_reg.t;
                                        pcnt_next = 6'd32 - {1'b0, it_reg.t};
                                    end
                                end
                                lsu_pkg::K_STWCX:
                                begin
                                    res_held_next = 1'b0;
                                    res_addr_next = lsu_pkg::NO_RESERVATION;
                                    out_next.cr0_valid = 1'b1;
                                    out_next.cr0_bits = (ok ? lsu_pkg::CR0_EQ : 4'd0)
                                                        | {3'd0, it_reg.so};
                                    if (ok)
                                    begin
                                        out_next.mem_op = lsu_pkg::MEM_WRITE;
                                        out_next.mem_address = ea_reg;
                                        out_next.mem_size = lsu_pkg::SIZE_W;
                                        out_next.mem_write_data = rt_reg;
                                    end
                                end
                                lsu_pkg::K_STB, lsu_pkg::K_STH, lsu_pkg::K_STW,
                                lsu_pkg::K_STHBRX, lsu_pkg::K_STWBRX:
                                begin
                                    out_next.mem_op = lsu_pkg::MEM_WRITE;
                                    out_next.mem_address = ea_reg;
                                    out_next.mem_size = it_reg.size;
                                    unique case (it_reg.kind)
                                        lsu_pkg::K_STB:
                                            out_next.mem_write_data = {24'd0, rt_reg[7:0]};
                                        lsu_pkg::K_STH:
                                            out_next.mem_write_data = {16'd0, rt_reg[15:0]};
                                        lsu_pkg::K_STHBRX:
                                            out_next.mem_write_data = lsu_pkg::swap16(rt_reg);
                                        lsu_pkg::K_STWBRX:
                                            out_next.mem_write_data = lsu_pkg::swap32(rt_reg);
                                        default: out_next.mem_write_data = rt_reg;
                                    endcase
                                    we = it_reg.upd;
                                    out_next.reg_write_valid = it_reg.upd;
                                    out_next.reg_index = it_reg.upd ? it_reg.a : 5'd0;
                                    out_next.reg_value = it_reg.upd ? ea_reg : 32'd0;
                                end
                                default:
                                begin
                                    pkind_next = it_reg.kind;
                                    pdest_next = it_reg.t;
                                    pcnt_next = 6'd1;
                                    if (it_reg.kind == lsu_pkg::K_LWARX)
                                    begin
                                        res_held_next = 1'b1;
                                        res_addr_next = ea_reg;
                                    end
                                    out_next.mem_op = lsu_pkg::MEM_READ;
                                    out_next.mem_address = ea_reg;
                                    out_next.mem_size = it_reg.size;
                                    we = it_reg.upd;
                                    out_next.reg_write_valid = it_reg.upd;
                                    out_next.reg_index = it_reg.upd ? it_reg.a : 5'd0;
                                    out_next.reg_value = it_reg.upd ? ea_reg : 32'd0;
                                end
                            endcase
                        end
                    endcase
                end
            end
            S_MRD:
            begin
                raddr = cur_reg;
                state_next = S_MOUT;
            end
            S_MOUT:
            begin
                // keep the word on the read port while the result waits
                raddr = cur_reg;
                if (out_free)
                begin
                    out_next = '0;
                    ov_next = 1'b1;
                    out_next.mem_address = maddr_reg;
                    out_next.mem_size = lsu_pkg::SIZE_W;
                    if (it_reg.kind == lsu_pkg::K_STMW)
                    begin
                        out_next.mem_op = lsu_pkg::MEM_WRITE;
                        out_next.mem_write_data = rdata_eff;
                    end
                    else
                    begin
                        out_next.mem_op = lsu_pkg::MEM_READ;
                    end
                    out_next.last = (cur_reg == 5'd31);
                    if (cur_reg == 5'd31)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next = cur_reg + 5'd1;
                        maddr_next = maddr_reg + 32'd4;
                        state_next = S_MRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (we)
        begin
            vbits_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        rt_reg <= rt_next;
        ea_reg <= ea_next;
        cur_reg <= cur_next;
        maddr_reg <= maddr_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vbits_reg <= '0;
            rvalid_reg <= 1'b0;
            pkind_reg <= 4'd0;
            pdest_reg <= 5'd0;
            pcnt_reg <= 6'd0;
            res_held_reg <= 1'b0;
            res_addr_reg <= lsu_pkg::NO_RESERVATION;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vbits_reg <= vbits_next;
            rvalid_reg <= vbits_reg[raddr];
            pkind_reg <= pkind_next;
            pdest_reg <= pdest_next;
            pcnt_reg <= pcnt_next;
            res_held_reg <= res_held_next;
            res_addr_reg <= res_addr_next;
            ov_reg <= ov_next;
        end
    end

endmodule

FILE: hdl/powerpc_load_store_unit.sv
// PowerPC integer load/store unit top level
// A two-entry queue decouples request decode from execution. An instruction reads its rA, rB
// and rS operands one per cycle through the single read port of the register file; lmw/stmw
// then take one register-file read per word. Results sit in one output register so the next
// request proceeds while a result waits. Registers read as zero until first written.
module powerpc_load_store_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // access_kind, update_form, indexed_form, target_reg, base_reg, index_reg,
    // displacement, data_value, overflow_summary
    input  logic [71:0]  s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mem_address, mem_size, mem_write_data, reg_write_valid, reg_index, reg_value,
    // cr0_valid, cr0_bits
    output logic [111:0] m_tdata,
    // mem_op
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic q_valid, q_ready;
    lsu_pkg::item_t q_item;
    lsu_pkg::result_t res;

    lsu_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    lsu_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tuser = res.mem_op;
    assign m_tlast = res.last;
    assign m_tdata = {3'd0, res.cr0_bits, res.cr0_valid, res.reg_value, res.reg_index,
                      res.reg_write_valid, res.mem_write_data, res.mem_size,
                      res.mem_address};

`ifndef SYNTHESIS
    a_cr0_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.cr0_valid |-> m_tlast)
        else $error("cr0 result not final");
    a_noop_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.mem_op == lsu_pkg::MEM_NONE |-> res.mem_address == 32'd0)
        else $error("address on result without access");
    a_regwr_store: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.cr0_valid |-> !res.reg_write_valid)
        else $error("stwcx wrote a register");
`endif

endmodule

FILE: verif/tb_powerpc_load_store_unit.sv
// testbench for the load/store unit: directed cases and random instruction streams checked against a predictor
module tb_powerpc_load_store_unit;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] mem_op;
        logic [31:0] mem_address;
        logic [1:0] mem_size;
        logic [31:0] mem_write_data;
        logic reg_write_valid;
        logic [4:0] reg_index;
        logic [31:0] reg_value;
        logic cr0_valid;
        logic [3:0] cr0_bits;
        logic last;
    } lsu_resp_t;

    class lsu_scoreboard;
        logic [31:0] gpr[32];
        logic [31:0] resv_addr;
        bit resv_held;
        logic [3:0] rd_kind;
        logic [4:0] rd_dest;
        int rd_count;
        lsu_resp_t pending[$];
        int errors;

        function void clear();
            foreach (gpr[i]) gpr[i] = '0;
            resv_addr = lsu_pkg::NO_RESERVATION;
            resv_held = 0;
            rd_kind = '0;
            rd_dest = '0;
            rd_count = 0;
            errors = 0;
        endfunction

        function void push(logic [1:0] op, logic [31:0] addr, logic [1:0] sz,
                           logic [31:0] wd, logic rv, logic [4:0] ri, logic [31:0] rval,
                           logic cv, logic [3:0] cb, logic lst);
            lsu_resp_t r;
            r.mem_op = op;
            r.mem_address = (op != lsu_pkg::MEM_NONE) ? addr : '0;
            r.mem_size = (op != lsu_pkg::MEM_NONE) ? sz : '0;
            r.mem_write_data = (op == lsu_pkg::MEM_WRITE) ? wd : '0;
            r.reg_write_valid = rv;
            r.reg_index = rv ? ri : '0;
            r.reg_value = rv ? rval : '0;
            r.cr0_valid = cv;
            r.cr0_bits = cv ? cb : '0;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_request(logic [1:0] op, logic [3:0] kind, logic upd, logic idx,
                                   logic [4:0] t, logic [4:0] a, logic [4:0] b,
                                   logic [15:0] disp, logic [31:0] d, logic so);
            logic [31:0] ea, v, s, wd;
            logic [1:0] sz;
            int n;
            bit ok;
            if (op == lsu_pkg::OP_RDATA) begin
                if (rd_count == 0) return;
                case (rd_kind)
                    lsu_pkg::K_LBZ: v = {24'd0, d[7:0]};
                    lsu_pkg::K_LHA: v = {{16{d[15]}}, d[15:0]};
                    lsu_pkg::K_LHZ: v = {16'd0, d[15:0]};
                    lsu_pkg::K_LHBRX: v = {16'd0, d[7:0], d[15:8]};
                    lsu_pkg::K_LWBRX: v = {d[7:0], d[15:8], d[23:16], d[31:24]};
                    default: v = d;
                endcase
                gpr[rd_dest] = v;
                push(lsu_pkg::MEM_NONE, 0, 0, 0, 1, rd_dest, v, 0, 0, 1);
                rd_dest = rd_dest + 5'd1;
                rd_count--;
                return;
            end
            if (op == lsu_pkg::OP_SETREG) begin
                gpr[t] = d;
                push(lsu_pkg::MEM_NONE, 0, 0, 0, 1, t, d, 0, 0, 1);
                return;
            end
            if (op != lsu_pkg::OP_INSTR) return;
            rd_count = 0;
            if (kind == lsu_pkg::K_NONE) return;
            if (kind >= lsu_pkg::K_LHBRX && kind != lsu_pkg::K_LMW && kind != lsu_pkg::K_STMW)
                idx = 1;
            if (kind == lsu_pkg::K_LMW || kind == lsu_pkg::K_STMW) idx = 0;
            if (kind > lsu_pkg::K_STW) upd = 0;
            ea = idx ? gpr[b] : {{16{disp[15]}}, disp};
            if (upd || a != 0) ea += gpr[a];
            case (kind)
                lsu_pkg::K_LBZ, lsu_pkg::K_LHA, lsu_pkg::K_LHZ, lsu_pkg::K_LWZ,
                lsu_pkg::K_LHBRX, lsu_pkg::K_LWBRX, lsu_pkg::K_LWARX:
                begin
                    sz = (kind == lsu_pkg::K_LBZ) ? lsu_pkg::SIZE_B :
                         (kind == lsu_pkg::K_LWZ || kind == lsu_pkg::K_LWBRX ||
                          kind == lsu_pkg::K_LWARX) ? lsu_pkg::SIZE_W : lsu_pkg::SIZE_H;
                    rd_kind = kind;
                    rd_dest = t;
                    rd_count = 1;
                    if (kind == lsu_pkg::K_LWARX)
                    begin
                        resv_addr = ea;
                        resv_held = 1;
                    end
                    if (upd) gpr[a] = ea;
                    push(lsu_pkg::MEM_READ, ea, sz, 0, upd, a, ea, 0, 0, 1);
                end
                lsu_pkg::K_STB, lsu_pkg::K_STH, lsu_pkg::K_STW, lsu_pkg::K_STHBRX,
                lsu_pkg::K_STWBRX:
                begin
                    s = gpr[t];
                    case (kind)
                        lsu_pkg::K_STB: begin sz = lsu_pkg::SIZE_B; wd = {24'd0, s[7:0]}; end
                        lsu_pkg::K_STH: begin sz = lsu_pkg::SIZE_H; wd = {16'd0, s[15:0]}; end
                        lsu_pkg::K_STW: begin sz = lsu_pkg::SIZE_W; wd = s; end
                        lsu_pkg::K_STHBRX:
                            begin sz = lsu_pkg::SIZE_H; wd = {16'd0, s[7:0], s[15:8]}; end
                        default:
                            begin
                                sz = lsu_pkg::SIZE_W;
                                wd = {s[7:0], s[15:8], s[23:16], s[31:24]};
                            end
                    endcase
                    if (upd) gpr[a] = ea;
                    push(lsu_pkg::MEM_WRITE, ea, sz, wd, upd, a, ea, 0, 0, 1);
                end
                lsu_pkg::K_LMW:
                begin
                    n = 32 - t;
                    rd_kind = kind;
                    rd_dest = t;
                    rd_count = n;
                    for (int i = 0; i < n; i++)
                        push(lsu_pkg::MEM_READ, ea + 4 * i, lsu_pkg::SIZE_W, 0, 0, 0, 0, 0, 0,
                             i + 1 == n);
                end
                lsu_pkg::K_STMW:
                begin
                    n = 32 - t;
                    for (int i = 0; i < n; i++)
                        push(lsu_pkg::MEM_WRITE, ea + 4 * i, lsu_pkg::SIZE_W,
                             gpr[(t + i) % 32], 0, 0, 0, 0, 0, i + 1 == n);
                end
                default:
                begin
                    ok = resv_held && ea == resv_addr;
                    push(ok ? lsu_pkg::MEM_WRITE : lsu_pkg::MEM_NONE, ea, lsu_pkg::SIZE_W,
                         gpr[t], 0, 0, 0, 1, {2'b00, ok, so}, 1);
                    resv_addr = lsu_pkg::NO_RESERVATION;
                    resv_held = 0;
                end
            endcase
        endfunction

        function void check_result(lsu_resp_t got);
            lsu_resp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.mem_op !== e.mem_op)
                begin $error("mem_op exp %h got %h", e.mem_op, got.mem_op); errors++; end
            if (got.mem_address !== e.mem_address)
                begin
                    $error("mem_address exp %h got %h", e.mem_address, got.mem_address);
                    errors++;
                end
            if (got.mem_size !== e.mem_size)
                begin $error("mem_size exp %h got %h", e.mem_size, got.mem_size); errors++; end
            if (got.mem_write_data !== e.mem_write_data)
                begin
                    $error("mem_write_data exp %h got %h", e.mem_write_data,
                           got.mem_write_data);
                    errors++;
                end
            if (got.reg_write_valid !== e.reg_write_valid)
                begin
                    $error("reg_write_valid exp %h got %h", e.reg_write_valid,
                           got.reg_write_valid);
                    errors++;
                end
            if (got.reg_index !== e.reg_index)
                begin $error("reg_index exp %h got %h", e.reg_index, got.reg_index); errors++; end
            if (got.reg_value !== e.reg_value)
                begin $error("reg_value exp %h got %h", e.reg_value, got.reg_value); errors++; end
            if (got.cr0_valid !== e.cr0_valid)
                begin $error("cr0_valid exp %h got %h", e.cr0_valid, got.cr0_valid); errors++; end
            if (got.cr0_bits !== e.cr0_bits)
                begin $error("cr0_bits exp %h got %h", e.cr0_bits, got.cr0_bits); errors++; end
            if (got.last !== e.last)
                begin $error("last exp %h got %h", e.last, got.last); errors++; end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [71:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [111:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    lsu_scoreboard sb;
    bit hold_off;
    bit stim_done;
    longint cycles;

    powerpc_load_store_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // leaves tvalid high; the caller drops it before any idle cycle
    task automatic send_request(logic [1:0] op, logic [3:0] kind, logic upd, logic idx,
                                logic [4:0] t, logic [4:0] a, logic [4:0] b,
                                logic [15:0] disp, logic [31:0] d, logic so);
        s_tuser <= op;
        s_tdata <= {2'b00, so, d, disp, b, a, t, idx, upd, kind};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, kind, upd, idx, t, a, b, disp, d, so);
        @(negedge clk);
    endtask

    task automatic random_gap();
        int n;
        if ($urandom_range(3) == 0)
        begin
            n = $urandom_range(6, 1);
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_raw(logic [1:0] op);
        logic [71:0] raw;
        raw = {8'($urandom), 32'($urandom), 32'($urandom)};
        send_request(op, raw[3:0], raw[4], raw[5], raw[10:6], raw[15:11], raw[20:16],
                     raw[36:21], raw[68:37], raw[69]);
    endtask

    task automatic send_instr(logic [3:0] kind, logic upd, logic idx, logic [4:0] t,
                              logic [4:0] a, logic [4:0] b, logic [15:0] disp);
        send_request(lsu_pkg::OP_INSTR, kind, upd, idx, t, a, b, disp, 32'($urandom),
                     1'($urandom_range(1)));
    endtask

    task automatic send_data();
        send_raw(lsu_pkg::OP_RDATA);
    endtask

    task automatic send_random_item();
        int pick;
        logic [3:0] kind;
        logic [4:0] t, a, b;
        pick = $urandom_range(99);
        kind = 4'($urandom_range(15));
        a = 5'($urandom);
        b = 5'($urandom);
        if (kind == lsu_pkg::K_LMW || kind == lsu_pkg::K_STMW)
            t = 5'($urandom_range(31, 24));
        else
            t = 5'($urandom);
        if (pick < 10)
            send_raw(lsu_pkg::OP_SETREG);
        else if (pick < 13)
            send_raw(lsu_pkg::OP_RDATA);
        else if (pick < 15)
            send_raw(OP_UNUSED);
        else
        begin
            if (kind == lsu_pkg::K_STWCX && $urandom_range(1) == 1)
            begin
                send_instr(lsu_pkg::K_LWARX, 1'b0, 1'b1, 5'($urandom), a, b, 16'($urandom));
                if ($urandom_range(1) == 1) send_data();
            end
            send_instr(kind, 1'($urandom), 1'($urandom), t, a, b, 16'($urandom));
            if (kind == lsu_pkg::K_LMW)
                repeat (32 - t - $urandom_range(1)) send_data();
            else if ($urandom_range(4) != 0)
                send_data();
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        hold_off = 0;
        stim_done = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: every kind, extremes, special cases
        send_request(lsu_pkg::OP_SETREG, lsu_pkg::K_LBZ, 1'b0, 1'b0, 5'd31, 5'd0, 5'd0,
                     16'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(lsu_pkg::OP_SETREG, lsu_pkg::K_LBZ, 1'b0, 1'b0, 5'd1, 5'd0, 5'd0,
                     16'd0, 32'h8001_80F0, 1'b0);
        for (int k = 0; k <= 14; k++)
        begin
            send_instr(4'(k), 1'b1, 1'b0, 5'd1, 5'd1, 5'd31, 16'h8000);
            if (4'(k) != lsu_pkg::K_LMW) send_data();
        end
        send_instr(lsu_pkg::K_LWZ, 1'b1, 1'b1, 5'd0, 5'd0, 5'd31, 16'h7FFF);
        send_instr(lsu_pkg::K_LHA, 1'b0, 1'b0, 5'd2, 5'd0, 5'd0, 16'hFFFF);
        send_request(lsu_pkg::OP_RDATA, lsu_pkg::K_LBZ, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0,
                     16'd0, 32'h0000_8000, 1'b0);
        send_data();
        send_instr(lsu_pkg::K_LWARX, 1'b0, 1'b1, 5'd3, 5'd31, 5'd1, 16'd0);
        send_instr(lsu_pkg::K_STWCX, 1'b0, 1'b1, 5'd3, 5'd31, 5'd1, 16'd0);
        send_instr(lsu_pkg::K_STWCX, 1'b0, 1'b1, 5'd3, 5'd31, 5'd1, 16'd0);
        send_instr(lsu_pkg::K_NONE, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0, 16'd0);
        send_instr(lsu_pkg::K_LMW, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0, 16'h0004);
        send_instr(lsu_pkg::K_STMW, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0, 16'h0000);

        // pause until drained
        s_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending.size() != 0);

        for (int n = 0; n < 70; n++)
        begin
            if (n == 20) hold_off = 1;
            send_random_item();
            random_gap();
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        int hold;
        m_tready = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            else
            begin
                hold = $urandom_range(15);
                m_tready <= (hold < 4) ? 1'b0 : 1'b1;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
        begin
            lsu_resp_t r;
            r.mem_op = m_tuser;
            {r.cr0_bits, r.cr0_valid, r.reg_value, r.reg_index, r.reg_write_valid,
             r.mem_write_data, r.mem_size, r.mem_address} = m_tdata[108:0];
            r.last = m_tlast;
            sb.check_result(r);
        end

    initial
    begin
        cycles = 0;
        wait (stim_done);
        while (sb.pending.size() != 0 && cycles < 400000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (50) @(posedge clk);
        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("tb_powerpc_load_store_unit passed");
        else
            $display("tb_powerpc_load_store_unit failed");
        $finish;
    end

    initial
    begin
        repeat (800000) @(posedge clk);
        $display("tb_powerpc_load_store_unit failed");
        $finish;
    end
endmodule
